// File: rtl/core/sla_pkg.sv
// Shared types and constants for the slot allocator.
// No dependencies; imported by sla_reuse_q and the top level.
package sla_pkg;

    // Fixed field widths
    localparam int CAP_W   = 11;
    localparam int INDEX_W = 10;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
    localparam int MAX_SLOTS_DEFAULT = 1024;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Control from the decision stage to the reuse queue
    typedef struct packed {
        logic clear;
        logic pop;
        logic push;
    } q_ctrl_t;

endpackage

// File: rtl/core/sla_bitmap.sv
// Allocated-bit store: one bit per slot, one write and one registered read per cycle.
// Depends on nothing but its parameter; instantiated by the top level.
module sla_bitmap #(
    parameter int MAX_SLOTS = 1024,
    parameter int SLOT_W    = $clog2(MAX_SLOTS)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  logic              wr_data,
    output logic              rd_data
);
    logic mem [MAX_SLOTS];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            // same-edge write wins over the stale entry
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/sla_reuse_q.sv
// Ring queue of released slot indices with head prefetch.
// Depends on sla_pkg (q_ctrl_t); instantiated by the top level.
module sla_reuse_q #(
    parameter int MAX_SLOTS = 1024,
    parameter int SLOT_W    = $clog2(MAX_SLOTS),
    parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sla_pkg::q_ctrl_t  ctrl,
    input  logic [SLOT_W-1:0] push_data,
    output logic [SLOT_W-1:0] head_data,
    output logic [CNT_W-1:0]  count
);
    import sla_pkg::*;

    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(MAX_SLOTS - 1);

    logic [SLOT_W-1:0] mem [MAX_SLOTS];
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] head_data_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);
        if (ctrl.pop)
        begin
            head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
        end
        if (ctrl.push)
        begin
            tail_next = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
        end
        if (ctrl.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // storage and head prefetch; a push landing on the new head is forwarded
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_data;
        end
        if (ctrl.push && (tail_reg == head_next))
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    assign head_data = head_data_reg;
    assign count     = count_reg;

endmodule

// File: rtl/core/slot_allocator_fifo_reuse_top.sv
// Slot allocator top level: request register, decision stage and result register.
// Depends on sla_pkg, sla_bitmap and sla_reuse_q.
//
// Command-style slot allocator. A request (mode, slot_index) is taken at every
// rising edge with start high; busy is never raised, so one request per cycle
// is sustained. Each request produces exactly one result, shown on
// granted_index/status for one cycle with done high. done rises at the edge
// after the accepting edge. The accepting edge also registers the allocated-bit
// read and the reuse queue head. The decision is then made combinationally and
// lands in the result register at the next edge.
// The receiver cannot stall; results must be captured when done is high.
// Allocate takes the oldest released index first, then the next never-used
// index below the capacity, else reports no free slot. Release checks range and
// double free before queueing the index for reuse. Writing a nonzero capacity
// over cfg_* clears all allocation state at once (no clearing pass): bits at or
// above the bump pointer read as free, so the bit store needs no reset. Capacity
// may only be written while no request is in flight; cfg_ready is always high.
module slot_allocator_fifo_reuse_top #(
    parameter int MAX_SLOTS = sla_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        mode,
    input  logic [sla_pkg::INDEX_W-1:0] slot_index,
    output logic                        done,
    output logic [sla_pkg::INDEX_W-1:0] granted_index,
    output logic [1:0]                  status,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sla_pkg::CAP_W-1:0]   cfg_data
);
    import sla_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    // common width for comparing capacity, counters and indices
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Handshakes
    logic accept;
    logic cfg_write;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready && (cfg_data != '0);

    // Configuration and bump pointer
    logic [CAP_W-1:0] capacity_reg;
    logic [CNT_W-1:0] next_fresh_reg, next_fresh_next;

    // Request register (stage 1)
    logic               s1_valid_reg;
    logic               s1_mode_reg;
    logic [INDEX_W-1:0] s1_index_reg;

    // Result register
    logic               done_reg;
    logic [INDEX_W-1:0] granted_reg, granted_next;
    status_t            status_reg, status_next;

    // Store interfaces
    logic [CMP_W-1:0]  in_idx_wide;
    logic [SLOT_W-1:0] rd_addr;
    logic              bit_rd;
    logic              bm_wr_en;
    logic [SLOT_W-1:0] bm_wr_addr;
    logic              bm_wr_data;
    q_ctrl_t           q_ctrl;
    logic [SLOT_W-1:0] q_head;
    logic [CNT_W-1:0]  q_count;

    assign in_idx_wide = CMP_W'(slot_index);
    assign rd_addr     = in_idx_wide[SLOT_W-1:0];

    sla_bitmap #(
        .MAX_SLOTS (MAX_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_bitmap (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (bm_wr_en),
        .wr_addr (bm_wr_addr),
        .wr_data (bm_wr_data),
        .rd_data (bit_rd)
    );

    sla_reuse_q #(
        .MAX_SLOTS (MAX_SLOTS),
        .SLOT_W    (SLOT_W),
        .CNT_W     (CNT_W)
    ) u_reuse_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q_ctrl),
        .push_data (bm_wr_addr),
        .head_data (q_head),
        .count     (q_count)
    );

    // Decision stage
    logic [CMP_W-1:0]  usable;
    logic [CMP_W-1:0]  s1_idx_wide;
    logic [CMP_W-1:0]  fresh_wide;
    logic [SLOT_W-1:0] grant_idx;
    logic [CMP_W-1:0]  grant_wide;
    logic              slot_busy;

    assign usable = (CMP_W'(capacity_reg) > CMP_W'(MAX_SLOTS))
                  ? CMP_W'(MAX_SLOTS) : CMP_W'(capacity_reg);
    assign s1_idx_wide = CMP_W'(s1_index_reg);
    assign fresh_wide  = CMP_W'(next_fresh_reg);
    // entries at or above the bump pointer were never written since the last clear
    assign slot_busy   = (s1_idx_wide < fresh_wide) && bit_rd;
    assign grant_wide  = CMP_W'(grant_idx);

    always_comb
    begin
        q_ctrl          = '0;
        q_ctrl.clear    = cfg_write;
        bm_wr_en        = 1'b0;
        bm_wr_addr      = s1_idx_wide[SLOT_W-1:0];
        bm_wr_data      = 1'b0;
        next_fresh_next = next_fresh_reg;
        grant_idx       = '0;
        status_next     = ST_OK;
        if (s1_valid_reg)
        begin
            if (!s1_mode_reg)
            begin
                if (q_count != '0)
                begin
                    grant_idx  = q_head;
                    q_ctrl.pop = 1'b1;
                    bm_wr_en   = 1'b1;
                    bm_wr_addr = q_head;
                    bm_wr_data = 1'b1;
                end
                else if (fresh_wide < usable)
                begin
                    grant_idx       = next_fresh_reg[SLOT_W-1:0];
                    bm_wr_en        = 1'b1;
                    bm_wr_addr      = next_fresh_reg[SLOT_W-1:0];
                    bm_wr_data      = 1'b1;
                    next_fresh_next = next_fresh_reg + 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            else
            begin
                if (s1_idx_wide >= usable)
                begin
                    status_next = ST_RANGE;
                end
                else if (!slot_busy)
                begin
                    status_next = ST_NOT_ALLOC;
                end
                else
                begin
                    bm_wr_en    = 1'b1;
                    bm_wr_data  = 1'b0;
                    q_ctrl.push = (q_count < CNT_W'(MAX_SLOTS));
                end
            end
        end
        if (cfg_write)
        begin
            next_fresh_next = '0;
        end
        granted_next = grant_wide[INDEX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAP_RESET;
            next_fresh_reg <= '0;
            s1_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
            status_reg     <= ST_OK;
        end
        else
        begin
            if (cfg_write)
            begin
                capacity_reg <= cfg_data;
            end
            next_fresh_reg <= next_fresh_next;
            s1_valid_reg   <= accept;
            done_reg       <= s1_valid_reg;
            status_reg     <= status_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg  <= mode;
            s1_index_reg <= slot_index;
        end
        granted_reg <= granted_next;
    end

    assign done          = done_reg;
    assign granted_index = granted_reg;
    assign status        = status_reg;

    // Every queued index was handed out by the bump pointer first
    a_queue_le_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(q_count) <= fresh_wide)
        else $error("reuse queue holds more indices than were ever handed out");

    // Bump pointer never passes the usable slot count
    a_fresh_le_usable: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_wide <= usable)
        else $error("bump pointer beyond usable capacity");

    // A request never both pops and pushes the reuse queue
    a_no_pop_push: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_ctrl.pop && q_ctrl.push))
        else $error("simultaneous pop and push");

    // Only a successful allocate returns a nonzero index
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status_reg != ST_OK) |-> granted_index == '0)
        else $error("nonzero index on failed request");

    // A result strobe follows every accepted request
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("missing result strobe");

endmodule
